/* design/base64_line_wrapped_encoder_defines.svh */
// Assertion macros used by the encoder's top-level RTL file.
`ifndef BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B64LWE_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("encoder assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define B64LWE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("encoder assertion failed: next-cycle implication");

`endif

/* design/b64lwe_pkg.sv */
// Package: shared types, constants and the alphabet function of the encoder.
`default_nettype none

package b64lwe_pkg;

   localparam int LINE_CHARS_DEFAULT = 76;
   localparam int QUEUE_DEPTH        = 2;
   localparam int QCOUNT_W           = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W             = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   // Kind of work handed from the front end to the back end.
   typedef enum logic [1:0] {
      JOB_FULL,   // three bytes, four characters, optional CR LF
      JOB_ONE,    // one trailing byte, two characters and "=="
      JOB_TWO     // two trailing bytes, three characters and "="
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         wrap;
      logic [7:0]   first;
      logic [7:0]   second;
      logic [7:0]   third;
   } job_type;

   typedef struct packed {
      logic                full;
      logic                not_empty;
      logic [QCOUNT_W-1:0] count;
   } q_status_type;

   // Standard base64 alphabet.
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] wide;
      wide = {2'b00, v};
      if (v < 6'd26)      return wide + 8'h41;
      else if (v < 6'd52) return wide + 8'h47;
      else if (v < 6'd62) return wide - 8'h04;
      else if (v == 6'd62) return 8'h2B;
      else                return 8'h2F;
   endfunction

endpackage

`default_nettype wire

/* design/b64lwe_ifs.sv */
// Handshake channel interfaces for raw bytes in and characters out.
`default_nettype none

interface b64lwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       final_byte;

   modport source (output valid, output in_byte, output final_byte, input ready);
   modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface b64lwe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_end;

   modport source (output valid, output out_char, output run_end, input ready);
   modport sink   (input valid, input out_char, input run_end, output ready);
endinterface

`default_nettype wire

/* design/b64lwe_front.sv */
// Front end: takes request bytes, groups them and queues encode jobs.
`default_nettype none

module b64lwe_front #(
   parameter int LINE_CHARS = b64lwe_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   b64lwe_req_if.sink              req,
   input  b64lwe_pkg::q_status_type q_status,
   output logic                    push_valid,
   output b64lwe_pkg::job_type     push_job
);

   // Full groups per line, clamped to what a 5-bit counter holds.
   localparam int GroupsRaw = LINE_CHARS / 4;
   localparam int Groups    = (GroupsRaw < 1) ? 1 : ((GroupsRaw > 31) ? 31 : GroupsRaw);

   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [4:0] groups_ff, groups_in;

   logic       accept;
   logic [5:0] grp_next;
   logic       wrap;

   assign req.ready = ~q_status.full;
   assign accept    = req.valid & req.ready;
   assign grp_next  = {1'b0, groups_ff} + 6'd1;
   assign wrap      = (grp_next >= 6'(Groups));

   // Grouping and job classification
   always_comb begin
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      held_count_in  = held_count_ff;
      groups_in      = groups_ff;
      push_valid     = 1'b0;
      push_job.kind  = b64lwe_pkg::JOB_FULL;
      push_job.wrap  = 1'b0;
      push_job.first = held_first_ff;
      push_job.second = held_second_ff;
      push_job.third = req.in_byte;
      if (accept) begin
         case (held_count_ff)
            2'd0: begin
               held_first_in = req.in_byte;
               held_count_in = 2'd1;
               if (req.final_byte) begin
                  push_valid      = 1'b1;
                  push_job.kind   = b64lwe_pkg::JOB_ONE;
                  push_job.first  = req.in_byte;
                  push_job.second = 8'h00;
                  push_job.third  = 8'h00;
               end
            end
            2'd1: begin
               held_second_in = req.in_byte;
               held_count_in  = 2'd2;
               if (req.final_byte) begin
                  push_valid      = 1'b1;
                  push_job.kind   = b64lwe_pkg::JOB_TWO;
                  push_job.second = req.in_byte;
                  push_job.third  = 8'h00;
               end
            end
            default: begin
               // third byte (a count of three acts as two)
               push_valid    = 1'b1;
               push_job.wrap = wrap;
               held_count_in = 2'd0;
               groups_in     = wrap ? 5'd0 : grp_next[4:0];
            end
         endcase
         if (req.final_byte) begin
            held_count_in = 2'd0;
            groups_in     = 5'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
         held_count_ff  <= 2'd0;
         groups_ff      <= 5'd0;
      end else begin
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         held_count_ff  <= held_count_in;
         groups_ff      <= groups_in;
      end
   end

endmodule

`default_nettype wire

/* design/b64lwe_queue.sv */
// Job queue: short FIFO between the front end and the back end.
`default_nettype none

module b64lwe_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  b64lwe_pkg::job_type      push_job,
   input  wire logic                pop,
   output b64lwe_pkg::job_type      head_job,
   output b64lwe_pkg::q_status_type q_status
);

   localparam int Depth  = b64lwe_pkg::QUEUE_DEPTH;
   localparam int PtrW   = b64lwe_pkg::QPTR_W;
   localparam int CountW = b64lwe_pkg::QCOUNT_W;

   b64lwe_pkg::job_type slots_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign do_push = push_valid & ~q_status.full;
   assign do_pop  = pop & q_status.not_empty;

   assign q_status.full      = (count_ff == CountW'(Depth));
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.count     = count_ff;
   assign head_job           = slots_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CountW'(1);
         2'b01:   count_in = count_ff - CountW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* design/b64lwe_back.sv */
// Back end: queued jobs become one character per cycle while the output is ready.
`default_nettype none

module b64lwe_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  b64lwe_pkg::job_type      head_job,
   input  b64lwe_pkg::q_status_type q_status,
   output logic                     pop,
   b64lwe_rsp_if.source             rsp
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       end_ff, end_in;

   logic       load;
   logic       last;
   logic [5:0] s0, s1, s2, s3;

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.run_end  = end_ff;

   assign load = ~valid_ff | rsp.ready;
   assign s0   = head_job.first[7:2];
   assign s1   = {head_job.first[1:0], head_job.second[7:4]};
   assign s2   = {head_job.second[3:0], head_job.third[7:6]};
   assign s3   = head_job.third[5:0];

   // Last character: six with a line break, else four
   assign last = (head_job.kind == b64lwe_pkg::JOB_FULL && head_job.wrap) ?
                 (idx_ff == 3'd5) : (idx_ff == 3'd3);

   // Character selection
   always_comb begin
      case (idx_ff)
         3'd0: char_in = b64lwe_pkg::sextet_char(s0);
         3'd1: char_in = b64lwe_pkg::sextet_char(s1);
         3'd2: char_in = (head_job.kind == b64lwe_pkg::JOB_ONE) ?
                         b64lwe_pkg::CHAR_PAD : b64lwe_pkg::sextet_char(s2);
         3'd3: char_in = (head_job.kind == b64lwe_pkg::JOB_FULL) ?
                         b64lwe_pkg::sextet_char(s3) : b64lwe_pkg::CHAR_PAD;
         3'd4: char_in = b64lwe_pkg::CHAR_CR;
         default: char_in = b64lwe_pkg::CHAR_LF;
      endcase
   end

   // Output register control
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      end_in   = end_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = q_status.not_empty;
         end_in   = last;
         if (q_status.not_empty) begin
            if (last) begin
               idx_in = 3'd0;
               pop    = 1'b1;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         end_ff  <= end_in;
      end
   end

endmodule

`default_nettype wire

/* design/base64_line_wrapped_encoder.sv */
// Top level: base64 encoder with CR LF line wrapping after full groups.
// Bytes enter on req_chan, one per request, with final_byte on the last byte of a
// message; characters leave on rsp_chan one per cycle while it is ready, run_end
// marking the last character caused by a byte. The front end groups bytes and
// queues one job per group or trailing partial group in a two-entry queue; the
// back end emits one character per cycle (four per group, six when the line
// breaks). A byte is taken in the cycle it is offered while the queue has room,
// so sustained throughput is set by the back end's single character port. A line
// wraps after LINE_CHARS/4 full groups (at least one, at most 31).
`default_nettype none
`include "base64_line_wrapped_encoder_defines.svh"

module base64_line_wrapped_encoder #(
   parameter int LINE_CHARS = b64lwe_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   b64lwe_req_if.sink    req_chan,
   b64lwe_rsp_if.source  rsp_chan
);

   logic                     push_valid;
   b64lwe_pkg::job_type      push_job;
   logic                     pop;
   b64lwe_pkg::job_type      head_job;
   b64lwe_pkg::q_status_type q_status;

   b64lwe_front #(
      .LINE_CHARS (LINE_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   b64lwe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_status   (q_status)
   );

   b64lwe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   // Checks across the front end, queue and back end
   `B64LWE_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push_valid, !q_status.full)
   `B64LWE_ASSERT_IMPLIES(a_pop_has_job, clock, reset, pop, q_status.not_empty)
   `B64LWE_ASSERT_IMPLIES(a_count_bounded, clock, reset, 1'b1, q_status.count <= b64lwe_pkg::QCOUNT_W'(b64lwe_pkg::QUEUE_DEPTH))
   `B64LWE_ASSERT_NEXT(a_pop_emits, clock, reset, pop, rsp_chan.valid && rsp_chan.run_end)

endmodule

`default_nettype wire

/* bench/base64_stream_checker.sv */
// Checker for the base64 encoder: watches both channels, predicts characters and compares.
`timescale 1ns / 100ps

module base64_stream_checker #(
   parameter int LINE_CHARS = b64lwe_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   b64lwe_req_if     req_chan,
   b64lwe_rsp_if     rsp_chan,
   output int        mismatches,
   output int        outstanding
);

   // Full groups per line: LINE_CHARS/4, kept within 1..31.
   localparam int GROUPS_PER_LINE = (LINE_CHARS / 4 < 1)  ? 1  :
                                    (LINE_CHARS / 4 > 31) ? 31 : LINE_CHARS / 4;

   localparam logic [511:0] DIGITS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_exp_type;

   char_exp_type expected_chars[$];
   char_exp_type oldest;
   int           errors = 0;

   // Mirror of the encoder's grouping state
   logic [7:0] pend_a      = 8'h00;
   logic [7:0] pend_b      = 8'h00;
   logic [1:0] pend_count  = 2'd0;
   logic [4:0] line_groups = 5'd0;

   function automatic logic [7:0] digit(input logic [5:0] v);
      return DIGITS[(63 - int'(v)) * 8 +: 8];
   endfunction

   // Characters caused by one request, run_end on the last of them
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] burst [0:5];
      int n;
      n = 0;
      if (pend_count == 2'd0) begin
         pend_a = b;
         pend_count = 2'd1;
      end else if (pend_count == 2'd1) begin
         pend_b = b;
         pend_count = 2'd2;
      end else begin
         burst[0] = digit(pend_a[7:2]);
         burst[1] = digit({pend_a[1:0], pend_b[7:4]});
         burst[2] = digit({pend_b[3:0], b[7:6]});
         burst[3] = digit(b[5:0]);
         n = 4;
         pend_count = 2'd0;
         line_groups = line_groups + 5'd1;
         // line full: break it, even when the message ends here
         if (int'(line_groups) >= GROUPS_PER_LINE) begin
            burst[4] = b64lwe_pkg::CHAR_CR;
            burst[5] = b64lwe_pkg::CHAR_LF;
            n = 6;
            line_groups = 5'd0;
         end
      end
      // Trailing partial group with padding; next message starts a fresh line
      if (fin) begin
         if (pend_count == 2'd1) begin
            burst[n]     = digit(pend_a[7:2]);
            burst[n + 1] = digit({pend_a[1:0], 4'b0000});
            burst[n + 2] = b64lwe_pkg::CHAR_PAD;
            burst[n + 3] = b64lwe_pkg::CHAR_PAD;
            n = n + 4;
         end else if (pend_count == 2'd2) begin
            burst[n]     = digit(pend_a[7:2]);
            burst[n + 1] = digit({pend_a[1:0], pend_b[7:4]});
            burst[n + 2] = digit({pend_b[3:0], 2'b00});
            burst[n + 3] = b64lwe_pkg::CHAR_PAD;
            n = n + 4;
         end
         pend_count = 2'd0;
         line_groups = 5'd0;
      end
      for (int i = 0; i < n; i++) begin
         expected_chars.push_back('{ch: burst[i], last: (i == n - 1)});
      end
   endtask

   task automatic log_error(input string what, input logic [7:0] exp_ch, input logic exp_last,
                            input logic [7:0] got_ch, input logic got_last);
      if (errors < 10) begin
         $display("[%0t] %s: expected char 0x%h run_end %b, got char 0x%h run_end %b",
                  $time, what, exp_ch, exp_last, got_ch, got_last);
      end
      errors++;
   endtask

   // Compare accepted characters first, then predict from the accepted request
   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         pend_a = 8'h00;
         pend_b = 8'h00;
         pend_count = 2'd0;
         line_groups = 5'd0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_chars.size() == 0) begin
               log_error("unexpected character", 8'h00, 1'b0,
                         rsp_chan.out_char, rsp_chan.run_end);
            end else begin
               oldest = expected_chars.pop_front();
               if (oldest.ch !== rsp_chan.out_char || oldest.last !== rsp_chan.run_end) begin
                  log_error("character mismatch", oldest.ch, oldest.last,
                            rsp_chan.out_char, rsp_chan.run_end);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            encode_byte(req_chan.in_byte, req_chan.final_byte);
         end
      end
      mismatches  <= errors;
      outstanding <= expected_chars.size();
   end

endmodule

/* bench/tb_base64_line_wrapped_encoder.sv */
// Testbench top for the base64 encoder: clock, reset, byte stimulus, backpressure, verdict.
`timescale 1ns / 100ps

module tb_base64_line_wrapped_encoder;

   localparam int RANDOM_BYTES = 345;
   localparam int TAIL_CYCLES  = 20;
   localparam int STALL_LIMIT  = 1000;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;

   b64lwe_req_if req_chan ();
   b64lwe_rsp_if rsp_chan ();

   base64_line_wrapped_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   base64_stream_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      else if (roll < 94) return $urandom_range(3, 6);
      else return $urandom_range(12, 40);
   endfunction

   // One request; valid stays high when the next one follows without a gap
   task automatic send_byte(input logic [7:0] data, input logic last, input bit no_gaps);
      int gap;
      gap = 0;
      if (!no_gaps && $urandom_range(0, 1) == 1) gap = gap_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.in_byte    <= data;
      req_chan.final_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Hold off the sender until every predicted character has come out
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Result side backpressure: random stalls with stretches of steady ready
   initial begin : rsp_backpressure
      int stall_left;
      int steady_left;
      stall_left = 0;
      steady_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (steady_left > 0) steady_left--;
            else if ($urandom_range(0, 99) < 3) steady_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 99) < 30) stall_left = gap_cycles();
         end
      end
   end

   // Ends the run when neither channel moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int msg_count;
      int len;
      int roll;
      bit no_gaps;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.final_byte = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: one and two trailing bytes, alphabet extremes, full groups
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'hFC, 1'b0, 1'b0);
      send_byte(8'h0F, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'hFB, 1'b0, 1'b0);
      send_byte(8'hEF, 1'b0, 1'b0);
      send_byte(8'hBE, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h10, 1'b0, 1'b1);
      send_byte(8'h83, 1'b1, 1'b1);
      send_byte(8'h4D, 1'b0, 1'b0);
      send_byte(8'h61, 1'b0, 1'b0);
      send_byte(8'h6E, 1'b0, 1'b0);
      send_byte(8'h21, 1'b1, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'h40, 1'b0, 1'b0);
      send_byte(8'h20, 1'b0, 1'b0);
      send_byte(8'h10, 1'b0, 1'b0);
      send_byte(8'h08, 1'b1, 1'b0);
      wait_for_drain();

      // Random messages; the first ends exactly on a full line, the second
      // wraps and then ends on a single trailing byte
      sent = 0;
      msg_count = 0;
      while (sent < RANDOM_BYTES) begin
         if (msg_count == 0) len = 57;
         else if (msg_count == 1) len = 61;
         else begin
            roll = $urandom_range(0, 99);
            if (roll < 80) len = $urandom_range(1, 12);
            else if (roll < 95) len = $urandom_range(13, 40);
            else len = $urandom_range(41, 90);
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == len - 1, no_gaps);
         end
         sent = sent + len;
         msg_count++;
         if ($urandom_range(0, 7) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/b64lwe_pkg.sv
design/b64lwe_ifs.sv
design/b64lwe_front.sv
design/b64lwe_queue.sv
design/b64lwe_back.sv
design/base64_line_wrapped_encoder.sv
bench/base64_stream_checker.sv
bench/tb_base64_line_wrapped_encoder.sv
